[sv/urh_pkg.sv]
package urh_pkg;

  // Default sizes for the top level parameters.
  localparam int HISTORY_DEPTH_DEF = 256;
  localparam int RAM_BYTES_DEF     = 2097152;

  // Input action codes.
  localparam logic ACT_UPLOAD = 1'b0;
  localparam logic ACT_QUERY  = 1'b1;

  // Result status codes.
  localparam logic STATUS_OK  = 1'b0;
  localparam logic STATUS_OOB = 1'b1;

  typedef struct packed {
    logic        action;
    logic [31:0] start_address;
    logic [31:0] span_length;
  } in_t;

  typedef struct packed {
    logic        status;
    logic [31:0] transfer_number;
    logic [31:0] total_bytes;
  } out_t;

endpackage

[sv/upload_range_history.sv]
// Channel  | Direction | Handshake            | Payload
// ---------+-----------+----------------------+------------------------------------------
// in       | input     | in_valid / in_ready  | in_data  (action, start_address, span_length)
// out      | output    | out_valid / out_ready| out_data (status, transfer_number, total_bytes)
//
// An upload passes the upload state (bounds check) and the result state on its way to
// the output register. A query reads the history through its single RAM read port, one
// entry per cycle into the shared coverage compare; it ends early on a hit.
// Reset (synchronous, active low) empties the history and clears the counters.
// The block accepts a new item while a finished result still waits in the output
// register; a result that finds the output register occupied holds until it drains.

module upload_range_history #(
  parameter int HISTORY_DEPTH = urh_pkg::HISTORY_DEPTH_DEF,
  parameter int RAM_BYTES     = urh_pkg::RAM_BYTES_DEF
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_ready,
  input  urh_pkg::in_t  in_data,
  output logic          out_valid,
  input  logic          out_ready,
  output urh_pkg::out_t out_data
);

  // Begin addresses lie below RAM_BYTES; end addresses may equal it.
  localparam int BEG_W  = $clog2(RAM_BYTES);
  localparam int END_W  = $clog2(RAM_BYTES + 1);
  localparam int SLOT_W = (HISTORY_DEPTH > 1) ? $clog2(HISTORY_DEPTH) : 1;
  localparam int CNT_W  = $clog2(HISTORY_DEPTH + 1);
  localparam int ENT_W  = BEG_W + END_W + 32;

  localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(HISTORY_DEPTH - 1);
  localparam logic [CNT_W-1:0]  FULL_CNT  = CNT_W'(HISTORY_DEPTH);
  localparam logic [31:0]       RAM_SIZE  = 32'(RAM_BYTES);

  typedef enum logic [3:0] {
    S_IDLE   = 4'b0001,
    S_UPLOAD = 4'b0010,
    S_SCAN   = 4'b0100,
    S_RESULT = 4'b1000
  } state_t;

  // Control state.
  state_t            state_r, state_nxt;
  logic [CNT_W-1:0]  count_r, count_nxt;     // valid entries in the history
  logic [SLOT_W-1:0] wr_ptr_r, wr_ptr_nxt;   // slot that the next upload writes
  logic [31:0]       counter_r, counter_nxt; // number of the last accepted upload
  logic [31:0]       total_r, total_nxt;     // wrapping byte total
  logic [CNT_W-1:0]  left_r, left_nxt;       // entries still to be read by a scan
  logic [SLOT_W-1:0] rd_slot_r, rd_slot_nxt; // slot that the scan reads next
  logic              rd_vld_r, rd_vld_nxt;   // RAM read data holds an entry to check
  logic              out_valid_r, out_valid_nxt;

  // Payload registers.
  logic [31:0]       addr_r, addr_nxt;
  logic [31:0]       len_r, len_nxt;
  logic [32:0]       last_r, last_nxt;       // query end, formed without wrapping
  urh_pkg::out_t     res_r, res_nxt;
  urh_pkg::out_t     out_data_r, out_data_nxt;

  // History RAM and compare unit signals.
  logic              ram_we;
  logic [ENT_W-1:0]  ram_wdata;
  logic              ram_re;
  logic [ENT_W-1:0]  ram_rdata;
  logic [BEG_W-1:0]  ent_begin;
  logic [END_W-1:0]  ent_end;
  logic [31:0]       ent_number;
  logic              cover_hit;

  logic              in_xfer;
  logic              oob;
  logic [31:0]       span_sum;
  logic [31:0]       next_number;
  logic              out_free;

  assign in_ready  = (state_r == S_IDLE);
  assign in_xfer   = in_valid && in_ready;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;
  assign out_free  = !out_valid_r || out_ready;

  // Bounds check of an upload: the span must lie wholly inside the sample RAM.
  assign oob         = (addr_r >= RAM_SIZE) || (len_r > (RAM_SIZE - addr_r));
  assign span_sum    = addr_r + len_r;
  assign next_number = counter_r + 32'd1;

  assign ram_we    = (state_r == S_UPLOAD) && !oob;
  assign ram_wdata = {addr_r[BEG_W-1:0], span_sum[END_W-1:0], next_number};
  assign ram_re    = (state_r == S_SCAN) && (left_r != '0);

  assign ent_begin  = ram_rdata[ENT_W-1 -: BEG_W];
  assign ent_end    = ram_rdata[32 +: END_W];
  assign ent_number = ram_rdata[31:0];

  urh_hist_ram #(
    .DEPTH  (HISTORY_DEPTH),
    .ADDR_W (SLOT_W),
    .DATA_W (ENT_W)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (wr_ptr_r),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (rd_slot_r),
    .rdata (ram_rdata)
  );

  urh_cover_cmp #(
    .BEG_W (BEG_W),
    .END_W (END_W)
  ) u_cmp (
    .span_start (addr_r),
    .span_last  (last_r),
    .ent_begin  (ent_begin),
    .ent_end    (ent_end),
    .hit        (cover_hit)
  );

  always_comb begin
    state_nxt     = state_r;
    count_nxt     = count_r;
    wr_ptr_nxt    = wr_ptr_r;
    counter_nxt   = counter_r;
    total_nxt     = total_r;
    left_nxt      = left_r;
    rd_slot_nxt   = rd_slot_r;
    rd_vld_nxt    = 1'b0;
    addr_nxt      = addr_r;
    len_nxt       = len_r;
    last_nxt      = last_r;
    res_nxt       = res_r;
    out_data_nxt  = out_data_r;
    out_valid_nxt = out_valid_r && !out_ready;

    unique case (state_r)
      S_IDLE: begin
        if (in_xfer) begin
          addr_nxt    = in_data.start_address;
          len_nxt     = in_data.span_length;
          last_nxt    = {1'b0, in_data.start_address} + {1'b0, in_data.span_length};
          // The scan starts at the newest entry and walks toward the oldest.
          left_nxt    = count_r;
          rd_slot_nxt = (wr_ptr_r == '0) ? LAST_SLOT : wr_ptr_r - SLOT_W'(1);
          if (in_data.action == urh_pkg::ACT_UPLOAD) begin
            state_nxt = S_UPLOAD;
          end else if (count_r == '0) begin
            res_nxt   = '{status: urh_pkg::STATUS_OK, transfer_number: 32'd0,
                          total_bytes: total_r};
            state_nxt = S_RESULT;
          end else begin
            state_nxt = S_SCAN;
          end
        end
      end

      S_UPLOAD: begin
        if (oob) begin
          res_nxt = '{status: urh_pkg::STATUS_OOB, transfer_number: 32'd0,
                      total_bytes: total_r};
        end else begin
          counter_nxt = next_number;
          total_nxt   = total_r + len_r;
          // A full history overwrites its oldest entry, which sits at the write slot.
          wr_ptr_nxt  = (wr_ptr_r == LAST_SLOT) ? '0 : wr_ptr_r + SLOT_W'(1);
          count_nxt   = (count_r == FULL_CNT) ? count_r : count_r + CNT_W'(1);
          res_nxt     = '{status: urh_pkg::STATUS_OK, transfer_number: next_number,
                          total_bytes: total_r + len_r};
        end
        state_nxt = S_RESULT;
      end

      S_SCAN: begin
        // One read is issued per cycle while entries remain; the entry read in the
        // previous cycle is checked now.
        if (left_r != '0) begin
          rd_vld_nxt  = 1'b1;
          left_nxt    = left_r - CNT_W'(1);
          rd_slot_nxt = (rd_slot_r == '0) ? LAST_SLOT : rd_slot_r - SLOT_W'(1);
        end
        priority if (rd_vld_r && cover_hit) begin
          res_nxt    = '{status: urh_pkg::STATUS_OK, transfer_number: ent_number,
                         total_bytes: total_r};
          rd_vld_nxt = 1'b0;
          state_nxt  = S_RESULT;
        end else if (left_r == '0) begin
          res_nxt    = '{status: urh_pkg::STATUS_OK, transfer_number: 32'd0,
                         total_bytes: total_r};
          rd_vld_nxt = 1'b0;
          state_nxt  = S_RESULT;
        end else begin
          // No hit yet and entries remain: the scan goes on.
          state_nxt = S_SCAN;
        end
      end

      S_RESULT: begin
        if (out_free) begin
          out_data_nxt  = res_r;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      wr_ptr_r    <= '0;
      counter_r   <= '0;
      total_r     <= '0;
      left_r      <= '0;
      rd_slot_r   <= '0;
      rd_vld_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      wr_ptr_r    <= wr_ptr_nxt;
      counter_r   <= counter_nxt;
      total_r     <= total_nxt;
      left_r      <= left_nxt;
      rd_slot_r   <= rd_slot_nxt;
      rd_vld_r    <= rd_vld_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    addr_r     <= addr_nxt;
    len_r      <= len_nxt;
    last_r     <= last_nxt;
    res_r      <= res_nxt;
    out_data_r <= out_data_nxt;
  end

`ifndef SYNTHESIS
  // The history never holds more entries than it has slots.
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= FULL_CNT)
    else $error("history entry count exceeds depth");

  // A scan never has more entries left to read than the history holds.
  a_scan_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SCAN) |-> (left_r <= count_r))
    else $error("scan runs past the valid entries");

  // An upload transfer always goes through the bounds check next.
  a_upload_path: assert property (@(posedge clk) disable iff (!rst_n)
    (in_xfer && (in_data.action == urh_pkg::ACT_UPLOAD)) |=> (state_r == S_UPLOAD))
    else $error("upload transfer skipped the upload step");

  // A new result is only loaded from the result state.
  a_out_source: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == S_RESULT))
    else $error("output valid raised outside the result state");
`endif

endmodule

[sv/urh_hist_ram.sv]
module urh_hist_ram #(
  parameter int DEPTH  = urh_pkg::HISTORY_DEPTH_DEF,
  parameter int ADDR_W = 8,
  parameter int DATA_W = 75
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [DATA_W-1:0] wdata,
  input  logic              re,
  input  logic [ADDR_W-1:0] raddr,
  output logic [DATA_W-1:0] rdata
);

  logic [DATA_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Read data is registered: it appears in the cycle after the read enable.
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

[sv/urh_cover_cmp.sv]
module urh_cover_cmp #(
  parameter int BEG_W = 21,
  parameter int END_W = 22
) (
  input  logic [31:0]      span_start,
  input  logic [32:0]      span_last,
  input  logic [BEG_W-1:0] ent_begin,
  input  logic [END_W-1:0] ent_end,
  output logic             hit
);

  logic [31:0] begin_ext;
  logic [32:0] end_ext;

  assign begin_ext = {{(32 - BEG_W){1'b0}}, ent_begin};
  assign end_ext   = {{(33 - END_W){1'b0}}, ent_end};

  // The entry covers the span when it starts no earlier and ends no later.
  assign hit = (span_start >= begin_ext) && (span_last <= end_ext);

endmodule

[tb/sv/urh_checker.sv]
`timescale 1ns / 1ps

module urh_checker #(
  parameter int HISTORY_DEPTH = urh_pkg::HISTORY_DEPTH_DEF,
  parameter int RAM_BYTES     = urh_pkg::RAM_BYTES_DEF
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  input  logic          in_ready,
  input  urh_pkg::in_t  in_data,
  input  logic          out_valid,
  input  logic          out_ready,
  input  urh_pkg::out_t out_data,
  output int            fail_count,
  output int            awaited,
  output int            results_seen,
  output int            rejected_uploads,
  output int            covered_queries,
  output int            total_wraps
);

  localparam logic [31:0] RAM_LIMIT = 32'(RAM_BYTES);

  // Shadow copy of the transfer history, kept as a ring like the block's own.
  logic [31:0] span_lo  [HISTORY_DEPTH];
  logic [31:0] span_hi  [HISTORY_DEPTH];
  logic [31:0] span_tag [HISTORY_DEPTH];
  int unsigned used_slots;
  int unsigned first_slot;
  logic [31:0] upload_seq;
  logic [31:0] byte_sum;

  urh_pkg::out_t expected_results[$];
  int   fails;
  int   seen;
  int   rejects;
  int   covers;
  int   wraps;

  function automatic urh_pkg::out_t predict_result(input urh_pkg::in_t item);
    urh_pkg::out_t res;
    logic [32:0]   reach;
    logic [31:0]   prev_sum;
    int unsigned   slot;
    int            k;
    res.status          = urh_pkg::STATUS_OK;
    res.transfer_number = '0;
    if (item.action == urh_pkg::ACT_UPLOAD) begin
      if (item.start_address >= RAM_LIMIT ||
          item.span_length > RAM_LIMIT - item.start_address) begin
        res.status = urh_pkg::STATUS_OOB;
        rejects++;
      end else begin
        upload_seq = upload_seq + 32'd1;
        prev_sum   = byte_sum;
        byte_sum   = byte_sum + item.span_length;
        if (byte_sum < prev_sum) wraps++;
        // A full history gives up its oldest entry to the new one.
        if (used_slots >= HISTORY_DEPTH) begin
          first_slot = (first_slot + 1) % HISTORY_DEPTH;
          used_slots = HISTORY_DEPTH - 1;
        end
        slot           = (first_slot + used_slots) % HISTORY_DEPTH;
        span_lo[slot]  = item.start_address;
        span_hi[slot]  = item.start_address + item.span_length;
        span_tag[slot] = upload_seq;
        used_slots++;
        res.transfer_number = upload_seq;
      end
    end else begin
      // The end of the span is formed in 33 bits so that it cannot wrap.
      reach = {1'b0, item.start_address} + {1'b0, item.span_length};
      for (k = int'(used_slots) - 1; k >= 0; k--) begin
        slot = (first_slot + k) % HISTORY_DEPTH;
        if (item.start_address >= span_lo[slot] && reach <= {1'b0, span_hi[slot]}) begin
          res.transfer_number = span_tag[slot];
          covers++;
          break;
        end
      end
    end
    res.total_bytes = byte_sum;
    return res;
  endfunction

  always @(posedge clk) begin
    urh_pkg::out_t exp_res;
    if (!rst_n) begin
      used_slots = 0;
      first_slot = 0;
      upload_seq = '0;
      byte_sum   = '0;
      expected_results.delete();
      fails   = 0;
      seen    = 0;
      rejects = 0;
      covers  = 0;
      wraps   = 0;
    end else begin
      if ($isunknown(out_valid)) begin
        $error("out_valid is unknown");
        fails++;
      end
      if (in_valid && in_ready) expected_results.push_back(predict_result(in_data));
      if (out_valid && out_ready) begin
        seen++;
        if (expected_results.size() == 0) begin
          $error("result transfer with no item waiting for it: %h", out_data);
          fails++;
        end else begin
          exp_res = expected_results.pop_front();
          if (out_data.status !== exp_res.status) begin
            $error("status mismatch: expected %0d, got %0d", exp_res.status,
                   out_data.status);
            fails++;
          end
          if (out_data.transfer_number !== exp_res.transfer_number) begin
            $error("transfer_number mismatch: expected %0d, got %0d",
                   exp_res.transfer_number, out_data.transfer_number);
            fails++;
          end
          if (out_data.total_bytes !== exp_res.total_bytes) begin
            $error("total_bytes mismatch: expected %0d, got %0d",
                   exp_res.total_bytes, out_data.total_bytes);
            fails++;
          end
        end
      end
    end
    fail_count       <= fails;
    awaited          <= expected_results.size();
    results_seen     <= seen;
    rejected_uploads <= rejects;
    covered_queries  <= covers;
    total_wraps      <= wraps;
  end

endmodule

[tb/sv/testbench.sv]
`timescale 1ns / 1ps

module testbench;

  localparam int HISTORY_DEPTH = urh_pkg::HISTORY_DEPTH_DEF;
  localparam int RAM_BYTES     = urh_pkg::RAM_BYTES_DEF;
  localparam logic [31:0] RAM_LIMIT = 32'(RAM_BYTES);

  // Random items, split around a burst of whole-RAM uploads that replaces
  // every entry of the history.
  localparam int RANDOM_ITEMS = 776;
  localparam int FILL_UPLOADS = 256;
  localparam int MAX_GAP      = 14;
  // The receiver stops once for this long, well after the directed part.
  localparam int HOLD_CYCLES  = 600;
  localparam int HOLD_AFTER   = 40;
  // A query that misses scans the whole history before its result appears.
  localparam int DRAIN_CYCLES = HISTORY_DEPTH + 8;
  // Longest legal quiet stretch is the long hold plus one full scan; this is
  // several times that.
  localparam int STALL_LIMIT  = 5000;

  logic          clk       = 1'b0;
  logic          rst_n     = 1'b0;
  logic          in_valid  = 1'b0;
  urh_pkg::in_t  in_data   = '0;
  logic          out_ready = 1'b0;
  logic          in_ready;
  logic          out_valid;
  urh_pkg::out_t out_data;

  int fail_count;
  int awaited;
  int results_seen;
  int rejected_uploads;
  int covered_queries;
  int total_wraps;

  // Spans of recent in-bounds uploads, used to aim queries at real history.
  typedef struct {
    logic [31:0] base;
    logic [31:0] size;
  } span_t;
  span_t recent_spans[$];

  int uploads_sent = 0;
  int queries_sent = 0;
  int items_sent   = 0;
  bit tx_steady    = 1'b0;
  bit rx_steady    = 1'b0;
  bit hold_done    = 1'b0;
  int quiet_cycles = 0;

  upload_range_history #(
    .HISTORY_DEPTH(HISTORY_DEPTH),
    .RAM_BYTES    (RAM_BYTES)
  ) DUT (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data)
  );

  urh_checker #(
    .HISTORY_DEPTH(HISTORY_DEPTH),
    .RAM_BYTES    (RAM_BYTES)
  ) history_check (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_data         (in_data),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_data        (out_data),
    .fail_count      (fail_count),
    .awaited         (awaited),
    .results_seen    (results_seen),
    .rejected_uploads(rejected_uploads),
    .covered_queries (covered_queries),
    .total_wraps     (total_wraps)
  );

  initial begin
    forever #10 clk = ~clk;
  end

  function automatic urh_pkg::in_t pack_item(input logic act, input logic [31:0] addr,
                                             input logic [31:0] len);
    urh_pkg::in_t item;
    item.action        = act;
    item.start_address = addr;
    item.span_length   = len;
    return item;
  endfunction

  // Draws one random item. Half are in-bounds uploads with random content,
  // a tenth are uploads that break the RAM bounds, and the rest are queries,
  // most of them aimed inside or just past a recently recorded span.
  function automatic urh_pkg::in_t random_item();
    int          pick;
    int          which;
    logic [31:0] addr;
    logic [31:0] len;
    logic [31:0] off;
    span_t       span;
    pick = $urandom_range(0, 99);
    if (pick < 50) begin
      addr  = $urandom_range(0, RAM_BYTES - 1);
      which = $urandom_range(0, 9);
      if (which == 0) len = '0;
      else if (which < 6) len = $urandom_range(0, 4096);
      else len = $urandom_range(0, RAM_LIMIT - addr);
      // Small lengths near the top of the RAM are clipped to stay in bounds.
      if (len > RAM_LIMIT - addr) len = RAM_LIMIT - addr;
      span.base = addr;
      span.size = len;
      recent_spans.push_back(span);
      if (recent_spans.size() > 64) recent_spans.delete(0);
      return pack_item(urh_pkg::ACT_UPLOAD, addr, len);
    end
    if (pick < 60) begin
      which = $urandom_range(0, 2);
      if (which == 0) begin
        // Start address beyond the RAM, any length.
        addr = $urandom_range(RAM_BYTES, 32'hFFFF_FFFF);
        len  = $urandom();
      end else if (which == 1) begin
        // Starts inside but runs just past the end of the RAM.
        addr = $urandom_range(0, RAM_BYTES - 1);
        len  = RAM_LIMIT - addr + 32'd1 + $urandom_range(0, 1000);
      end else begin
        addr = $urandom_range(0, RAM_BYTES - 1);
        len  = $urandom();
      end
      return pack_item(urh_pkg::ACT_UPLOAD, addr, len);
    end
    if (pick < 90 && recent_spans.size() > 0) begin
      span = recent_spans[$urandom_range(0, recent_spans.size() - 1)];
      off  = $urandom_range(0, span.size);
      len  = $urandom_range(0, span.size - off);
      // Now and then the query reaches one byte past the chosen span.
      if ($urandom_range(0, 4) == 0) len = len + 32'd1;
      return pack_item(urh_pkg::ACT_QUERY, span.base + off, len);
    end
    if ($urandom_range(0, 1) == 0) begin
      return pack_item(urh_pkg::ACT_QUERY, $urandom(), $urandom());
    end
    addr = $urandom_range(0, RAM_BYTES - 1);
    return pack_item(urh_pkg::ACT_QUERY, addr, $urandom_range(0, 65536));
  endfunction

  // Offers one item after a random gap and returns once it is transferred.
  // Every 32 items the sender decides whether to run without gaps for a while.
  task automatic send_item(input urh_pkg::in_t item);
    int gap;
    if (items_sent % 32 == 0) tx_steady = ($urandom_range(0, 3) == 0);
    gap = tx_steady ? 0 : $urandom_range(0, MAX_GAP);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= item;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    items_sent++;
    if (item.action == urh_pkg::ACT_UPLOAD) uploads_sent++;
    else queries_sent++;
  endtask

  // Result side: a random stall before each transfer, with stretches of no
  // stalls, and one long hold-off so that the block fills up and refuses input
  // while the sender keeps offering.
  initial begin
    int stall;
    int taken;
    taken = 0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      if (taken % 32 == 0) rx_steady = ($urandom_range(0, 3) == 0);
      stall = rx_steady ? 0 : $urandom_range(0, MAX_GAP);
      if (!hold_done && results_seen >= HOLD_AFTER) begin
        stall     = HOLD_CYCLES;
        hold_done = 1'b1;
      end
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ready <= 1'b1;
      @(posedge clk);
      while (!out_valid) @(posedge clk);
      taken++;
    end
  end

  // Watchdog: a run in which no transfer happens on either channel for too
  // long is a hang.
  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles == STALL_LIMIT) begin
        $display("FAIL upload_range_history");
        $finish;
      end
    end
  end

  initial begin
    int n;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed part. A query on the empty history finds nothing.
    send_item(pack_item(urh_pkg::ACT_QUERY, '0, '0));
    // The whole RAM in one upload is accepted.
    send_item(pack_item(urh_pkg::ACT_UPLOAD, '0, RAM_LIMIT));
    // Bounds violations: start one past the end, one byte too long, and all ones.
    send_item(pack_item(urh_pkg::ACT_UPLOAD, RAM_LIMIT, '0));
    send_item(pack_item(urh_pkg::ACT_UPLOAD, '0, RAM_LIMIT + 32'd1));
    send_item(pack_item(urh_pkg::ACT_UPLOAD, 32'hFFFF_FFFF, 32'hFFFF_FFFF));
    // The last byte of the RAM, then an empty range, then a short range.
    send_item(pack_item(urh_pkg::ACT_UPLOAD, RAM_LIMIT - 32'd1, 32'd1));
    send_item(pack_item(urh_pkg::ACT_UPLOAD, 32'h0000_1000, '0));
    send_item(pack_item(urh_pkg::ACT_UPLOAD, 32'h0000_2000, 32'h0000_0100));
    // An empty query on an empty range is covered by it.
    send_item(pack_item(urh_pkg::ACT_QUERY, 32'h0000_1000, '0));
    // Exact match, empty span at the end, and one byte too long.
    send_item(pack_item(urh_pkg::ACT_QUERY, 32'h0000_2000, 32'h0000_0100));
    send_item(pack_item(urh_pkg::ACT_QUERY, 32'h0000_2100, '0));
    send_item(pack_item(urh_pkg::ACT_QUERY, 32'h0000_2000, 32'h0000_0101));
    // Spans whose end overflows 32 bits must not wrap into a hit.
    send_item(pack_item(urh_pkg::ACT_QUERY, 32'h0000_2000, 32'hFFFF_FFFF));
    send_item(pack_item(urh_pkg::ACT_QUERY, 32'hFFFF_FFFF, 32'hFFFF_FFFF));
    // Empty span at the very end of the RAM, then the last byte.
    send_item(pack_item(urh_pkg::ACT_QUERY, RAM_LIMIT, '0));
    send_item(pack_item(urh_pkg::ACT_QUERY, RAM_LIMIT - 32'd1, 32'd1));
    send_item(pack_item(urh_pkg::ACT_UPLOAD, RAM_LIMIT - 32'd1, '0));
    send_item(pack_item(urh_pkg::ACT_QUERY, 32'h0001_2345, 32'h0000_0010));

    // Random part, with the fill burst in the middle so that later queries
    // start from a history filled with whole-RAM ranges.
    for (n = 0; n < RANDOM_ITEMS / 2; n++) send_item(random_item());
    for (n = 0; n < FILL_UPLOADS; n++) begin
      send_item(pack_item(urh_pkg::ACT_UPLOAD, '0, RAM_LIMIT));
    end
    for (n = 0; n < RANDOM_ITEMS - RANDOM_ITEMS / 2; n++) send_item(random_item());
    in_valid <= 1'b0;

    // The checker's counts are registered, so the bench steps the clock before looking.
    @(posedge clk);
    while (awaited != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Sent %0d uploads (%0d refused as out of bounds) and %0d queries (%0d covered).",
             uploads_sent, rejected_uploads, queries_sent, covered_queries);
    $display("Checked %0d results; the byte total wrapped %0d time(s).",
             results_seen, total_wraps);
    if (fail_count == 0) begin
      $display("PASS upload_range_history");
    end else begin
      $display("FAIL upload_range_history");
    end
    $finish;
  end

endmodule
